/* rtl/core/jet_pkg.sv */
// Shared types, constants and helper functions of the Julia escape-time pixel colorer.
package jet_pkg;

    localparam int ZW        = 32;
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 3;
    localparam int ITER_W    = 9;
    localparam int BAND_W    = 3;

    localparam logic [ITER_W-1:0] LIMIT_CAP = 9'd299;
    localparam logic [BAND_W-1:0] BAND_MAX  = 3'd5;

    localparam logic [CFG_AW-1:0] REG_HALF_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HALF_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_STEP_RE     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_STEP_IM     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CONST_RE    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_CONST_IM    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_ITER_LIMIT  = 3'd6;

    typedef struct packed {
        logic [15:0] pixel_col;
        logic [15:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [ITER_W-1:0] iter_count;
        logic              escaped;
    } t_color;

    typedef struct packed {
        logic [14:0]        half_width;
        logic [14:0]        half_height;
        logic [30:0]        step_re;
        logic [30:0]        step_im;
        logic signed [31:0] const_re;
        logic signed [31:0] const_im;
        logic [ITER_W-1:0]  iter_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [ZW-1:0] zr;
        logic signed [ZW-1:0] zi;
    } t_job;

    function automatic logic signed [ZW-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[ZW-1:0];
        end
    endfunction

    function automatic logic [23:0] band_color(input logic [BAND_W-1:0] band);
        case (band)
            3'd0:    band_color = {8'd50, 8'd0, 8'd0};
            3'd1:    band_color = {8'd255, 8'd0, 8'd0};
            3'd2:    band_color = {8'd0, 8'd255, 8'd0};
            3'd3:    band_color = {8'd0, 8'd0, 8'd255};
            3'd4:    band_color = {8'd100, 8'd70, 8'd0};
            3'd5:    band_color = {8'd40, 8'd150, 8'd0};
            default: band_color = {8'd50, 8'd0, 8'd0};
        endcase
    endfunction

endpackage

/* rtl/core/julia_escape_time_pixel_color.sv */
// Top level of the Julia escape-time pixel colorer with its configuration registers.
// Each pixel transaction is mapped to a Q8.24 start value in the front end, queued, and then
// iterated by one shared complex-square unit that works through each iteration in the states
// S_MUL (multiply) and then S_UPD (update and escape test); the iteration limit is capped at 299.
// New pixels are accepted into the front end and the two-entry queue while the engine is busy,
// and the engine starts the next pixel once its result register has been popped.
module julia_escape_time_pixel_color #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 24,
    parameter int BAND_SIZE  = 50
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  jet_pkg::t_pixel             i_pixel,
    output logic                        empty,
    input  logic                        pop,
    output jet_pkg::t_color             o_result,
    input  logic                        i_cfg_wr_en,
    input  logic [jet_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [jet_pkg::CFG_DW-1:0]  i_cfg_data
);
    import jet_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job q_job;
    logic front_wr;
    logic q_full;
    logic q_empty;
    logic q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width  <= 15'd5000;
            r_cfg.half_height <= 15'd5000;
            r_cfg.step_re     <= 31'd5033;
            r_cfg.step_im     <= 31'd5033;
            r_cfg.const_re    <= -32'sd13421773;
            r_cfg.const_im    <= 32'sd2617246;
            r_cfg.iter_limit  <= 9'd250;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_HALF_WIDTH:  r_cfg.half_width  <= i_cfg_data[14:0];
                REG_HALF_HEIGHT: r_cfg.half_height <= i_cfg_data[14:0];
                REG_STEP_RE:     r_cfg.step_re     <= i_cfg_data[30:0];
                REG_STEP_IM:     r_cfg.step_im     <= i_cfg_data[30:0];
                REG_CONST_RE:    r_cfg.const_re    <= $signed(i_cfg_data);
                REG_CONST_IM:    r_cfg.const_im    <= $signed(i_cfg_data);
                REG_ITER_LIMIT:  r_cfg.iter_limit  <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    jet_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_pixel (i_pixel),
        .i_cfg   (r_cfg),
        .i_q_full(q_full),
        .o_job_wr(front_wr),
        .o_job   (front_job)
    );

    jet_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (front_wr),
        .i_wr_data(front_job),
        .o_full   (q_full),
        .i_rd     (q_take),
        .o_rd_data(q_job),
        .o_empty  (q_empty)
    );

    jet_back #(
        .FRAC_BITS(FRAC_BITS),
        .BAND_SIZE(BAND_SIZE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!q_empty),
        .i_job      (q_job),
        .o_job_take (q_take),
        .i_cfg      (r_cfg),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

endmodule

/* rtl/core/jet_front.sv */
// Front end: accepts pixel coordinates and maps them to saturated complex start values.
module jet_front #(
    parameter int COORD_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  jet_pkg::t_pixel i_pixel,
    input  jet_pkg::t_cfg   i_cfg,
    input  logic            i_q_full,
    output logic            o_job_wr,
    output jet_pkg::t_job   o_job
);
    import jet_pkg::*;

    logic               r_valid;
    logic signed [48:0] r_prod_re;
    logic signed [48:0] r_prod_im;
    logic [15:0]        col;
    logic [15:0]        row;
    logic signed [16:0] diff_re;
    logic signed [16:0] diff_im;
    logic               accept;

    always_comb begin
        col = 16'(i_pixel.pixel_col[COORD_BITS-1:0]);
        row = 16'(i_pixel.pixel_row[COORD_BITS-1:0]);
        diff_re = $signed({2'b00, i_cfg.half_width}) - $signed({1'b0, col});
        diff_im = $signed({2'b00, i_cfg.half_height}) - $signed({1'b0, row});
    end

    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_job_wr = r_valid && !i_q_full;
    assign o_job.zr = sat32(64'(r_prod_re));
    assign o_job.zi = sat32(64'(r_prod_im));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_job_wr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_re <= $signed({1'b0, i_cfg.step_re}) * diff_re;
            r_prod_im <= $signed({1'b0, i_cfg.step_im}) * diff_im;
        end
    end

endmodule

/* rtl/core/jet_fifo.sv */
// Two-entry queue of start values between the front end and the iteration engine.
module jet_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  jet_pkg::t_job i_wr_data,
    output logic          o_full,
    input  logic          i_rd,
    output jet_pkg::t_job o_rd_data,
    output logic          o_empty
);
    import jet_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_wr;
    logic       do_rd;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 2'd1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* rtl/core/jet_back.sv */
// Iteration engine: runs z = z*z + c until escape or limit and holds the colored result.
module jet_back #(
    parameter int FRAC_BITS = 24,
    parameter int BAND_SIZE = 50
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  jet_pkg::t_job  i_job,
    output logic           o_job_take,
    input  jet_pkg::t_cfg  i_cfg,
    output logic           empty,
    input  logic           pop,
    output jet_pkg::t_color o_result
);
    import jet_pkg::*;

    localparam int BCW = $clog2(BAND_SIZE + 1);
    localparam logic [BCW-1:0] BAND_LAST = BCW'(BAND_SIZE - 1);
    localparam logic [63:0] THRESH = 64'd1 << (2 * FRAC_BITS + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]           r_state;
    logic signed [ZW-1:0] r_zr;
    logic signed [ZW-1:0] r_zi;
    logic signed [63:0]   r_prr;
    logic signed [63:0]   r_pii;
    logic signed [63:0]   r_pri;
    logic [ITER_W-1:0]    r_iter;
    logic [ITER_W-1:0]    r_limit;
    logic [BCW-1:0]       r_bcnt;
    logic [BAND_W-1:0]    r_band;
    logic                 r_first;
    logic                 r_res_valid;
    t_color               r_res;

    logic [ITER_W-1:0]    lim;
    logic signed [63:0]   re2;
    logic signed [63:0]   im2;
    logic signed [63:0]   cross_term;
    logic signed [ZW-1:0] new_re;
    logic signed [ZW-1:0] new_im;
    logic [63:0]          mag;
    logic                 escape;

    always_comb begin
        lim        = (i_cfg.iter_limit > LIMIT_CAP) ? LIMIT_CAP : i_cfg.iter_limit;
        re2        = r_prr >>> FRAC_BITS;
        im2        = r_pii >>> FRAC_BITS;
        cross_term = r_pri >>> (FRAC_BITS - 1);
        new_re     = sat32(re2 - im2 + 64'(i_cfg.const_re));
        new_im     = sat32(cross_term + 64'(i_cfg.const_im));
        mag        = $unsigned(r_prr) + $unsigned(r_pii);
        escape     = mag > THRESH;
    end

    assign o_job_take = (r_state == S_IDLE) && i_job_valid && !r_res_valid;
    assign empty      = !r_res_valid;
    assign o_result   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if (pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_job_take) begin
                        r_zr    <= i_job.zr;
                        r_zi    <= i_job.zi;
                        r_limit <= lim;
                        r_first <= 1'b1;
                        if (lim == '0) begin
                            {r_res.red, r_res.green, r_res.blue} <= band_color('0);
                            r_res.iter_count <= '0;
                            r_res.escaped    <= 1'b0;
                            r_res_valid      <= 1'b1;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prr   <= r_zr * r_zr;
                    r_pii   <= r_zi * r_zi;
                    r_pri   <= r_zr * r_zi;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_first) begin
                        r_zr    <= new_re;
                        r_zi    <= new_im;
                        r_iter  <= '0;
                        r_bcnt  <= '0;
                        r_band  <= '0;
                        r_first <= 1'b0;
                        r_state <= S_MUL;
                    end else if (escape) begin
                        {r_res.red, r_res.green, r_res.blue} <= band_color(r_band);
                        r_res.iter_count <= r_iter;
                        r_res.escaped    <= 1'b1;
                        r_res_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end else if (r_iter + ITER_W'(1) == r_limit) begin
                        {r_res.red, r_res.green, r_res.blue} <= band_color('0);
                        r_res.iter_count <= r_limit;
                        r_res.escaped    <= 1'b0;
                        r_res_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end else begin
                        r_zr   <= new_re;
                        r_zi   <= new_im;
                        r_iter <= r_iter + ITER_W'(1);
                        if (r_bcnt == BAND_LAST) begin
                            r_bcnt <= '0;
                            if (r_band != BAND_MAX) begin
                                r_band <= r_band + BAND_W'(1);
                            end
                        end else begin
                            r_bcnt <= r_bcnt + BCW'(1);
                        end
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
